@@ rtl/days_between_dates_assert.svh @@
// ---------------------------------------------------------------------------
// days_between_dates_assert.svh
// assertion macros for the days_between_dates checker
// ---------------------------------------------------------------------------
`ifndef DAYS_BETWEEN_DATES_ASSERT_SVH
`define DAYS_BETWEEN_DATES_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("days_between_dates: assertion failed");

// next-cycle implication, checked outside reset
`define DBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("days_between_dates: assertion failed");

`endif

@@ rtl/dbd_pkg.sv @@
// ---------------------------------------------------------------------------
// dbd_pkg
// shared constants, types and calendar tables for days_between_dates
// ---------------------------------------------------------------------------
package dbd_pkg;

    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int YEAR_W     = 15;
    localparam int DAY_NUM_W  = 24;
    localparam int DIST_W     = 23;
    localparam int SHIFT_YR_W = 16;

    // shift that makes every 15-bit year positive, a multiple of 400
    localparam logic [SHIFT_YR_W-1:0] YEAR_SHIFT = 16'd16400;

    // x / 25 == (x * RECIP_25) >> RECIP_SHIFT, exact for x below 43690
    localparam logic [15:0] RECIP_25    = 16'd41944;
    localparam int          RECIP_SHIFT = 20;

    localparam logic [DIST_W-1:0] DIST_MAX = 23'h7FFFFF;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    // per-date result handed from the date unit to the top level
    typedef struct packed {
        logic                 ok;
        logic [DAY_NUM_W-1:0] day_num;
    } date_res_t;

    // length of a month in a common year
    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
        logic [4:0] len;
        case (m) inside
            MONTH_FEB:                 len = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the common year before the first of the month
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] cum;
        case (m)
            4'd1:    cum = 9'd0;
            4'd2:    cum = 9'd31;
            4'd3:    cum = 9'd59;
            4'd4:    cum = 9'd90;
            4'd5:    cum = 9'd120;
            4'd6:    cum = 9'd151;
            4'd7:    cum = 9'd181;
            4'd8:    cum = 9'd212;
            4'd9:    cum = 9'd243;
            4'd10:   cum = 9'd273;
            4'd11:   cum = 9'd304;
            4'd12:   cum = 9'd334;
            default: cum = 9'd0;
        endcase
        return cum;
    endfunction

endpackage

@@ rtl/days_between_dates.sv @@
// ---------------------------------------------------------------------------
// days_between_dates
// distance in days between two gregorian dates; while m_ is not stalled, one date pair per cycle
// ---------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                         tuser
// s_       in   first_day, first_month, first_year,        -
//               second_day, second_month, second_year
// m_       out  day_distance, one zero pad bit             invalid_date
//
// one item per cycle while m_ is not stalled
// four register stages: reciprocal products, leap counts, day numbers,
// distance with saturation; the products set the stage depth
// reset clears the valid bits only, no clearing pass
// a stall on m_ holds the whole pipeline; apart from reset, s_tready falls only then
// ---------------------------------------------------------------------------
module days_between_dates (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_day, first_month, first_year, second_day, second_month, second_year
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_distance, zero pad bit
    output logic [23:0] m_tdata,
    // invalid_date
    output logic [0:0]  m_tuser
);
    import dbd_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg, out_v_reg;

    // pipeline advances unless the output item is stalled
    assign en       = !out_v_reg || m_tready;
    assign s_tready = aresetn && en;

    // valid bits travel alongside the date stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_v_reg <= v3_reg;
        end
    end

    // two date units
    date_res_t res_a, res_b;

    dbd_date_num u_date_a (
        .aclk  (aclk),
        .en    (en),
        .day   (s_tdata[4:0]),
        .month (s_tdata[8:5]),
        .year  (signed'(s_tdata[23:9])),
        .res   (res_a)
    );

    dbd_date_num u_date_b (
        .aclk  (aclk),
        .en    (en),
        .day   (s_tdata[28:24]),
        .month (s_tdata[32:29]),
        .year  (signed'(s_tdata[47:33])),
        .res   (res_b)
    );

    // stage 4: absolute difference with saturation, zero for an invalid pair
    logic [DAY_NUM_W-1:0] diff;
    logic [DIST_W-1:0]    dist_next, dist_reg;
    logic                 invalid_next, invalid_reg;

    always_comb begin
        diff = (res_a.day_num > res_b.day_num) ? (res_a.day_num - res_b.day_num)
                                               : (res_b.day_num - res_a.day_num);
        invalid_next = !(res_a.ok && res_b.ok);
        if (invalid_next) begin
            dist_next = '0;
        end else if (diff > DAY_NUM_W'(DIST_MAX)) begin
            dist_next = DIST_MAX;
        end else begin
            dist_next = diff[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg    <= dist_next;
            invalid_reg <= invalid_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {1'b0, dist_reg};
    assign m_tuser  = invalid_reg;

endmodule

@@ rtl/dbd_date_num.sv @@
// ---------------------------------------------------------------------------
// dbd_date_num
// three-stage day number and validity of one date
// ---------------------------------------------------------------------------
module dbd_date_num (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [dbd_pkg::DAY_W-1:0]      day,
    input  logic [dbd_pkg::MONTH_W-1:0]    month,
    input  logic signed [dbd_pkg::YEAR_W-1:0] year,
    output dbd_pkg::date_res_t             res
);
    import dbd_pkg::*;

    // stage 1: shifted year and reciprocal products
    logic [SHIFT_YR_W-1:0] t_next, n_next;
    logic [29:0]           p_n4_next, p_t4_next;
    logic [27:0]           p_n16_next;

    logic [SHIFT_YR_W-1:0] t1_reg, n1_reg;
    logic [29:0]           p_n4_reg, p_t4_reg;
    logic [27:0]           p_n16_reg;
    logic                  pos1_reg, yzero1_reg;
    logic [DAY_W-1:0]      day1_reg;
    logic [MONTH_W-1:0]    month1_reg;

    always_comb begin
        t_next     = SHIFT_YR_W'(signed'(year)) + YEAR_SHIFT;
        n_next     = t_next - 16'd1;
        p_n4_next  = 30'(n_next[15:2]) * 30'(RECIP_25);
        p_t4_next  = 30'(t_next[15:2]) * 30'(RECIP_25);
        p_n16_next = 28'(n_next[15:4]) * 28'(RECIP_25);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg      <= t_next;
            n1_reg      <= n_next;
            p_n4_reg    <= p_n4_next;
            p_t4_reg    <= p_t4_next;
            p_n16_reg   <= p_n16_next;
            pos1_reg    <= !year[YEAR_W-1] && (year != '0);
            yzero1_reg  <= (year == '0);
            day1_reg    <= day;
            month1_reg  <= month;
        end
    end

    // stage 2: leap count, leap flag and year base
    logic [8:0]           q_n100, q_t100;
    logic [6:0]           q_n400;
    logic [13:0]          leaps;
    logic [13:0]          rem_t100;
    logic                 leap_next;
    logic [DAY_NUM_W-1:0] base_next;

    logic [DAY_NUM_W-1:0] base2_reg;
    logic                 leap2_reg, pos2_reg, yzero2_reg;
    logic [DAY_W-1:0]     day2_reg;
    logic [MONTH_W-1:0]   month2_reg;

    always_comb begin
        q_n100    = p_n4_reg[RECIP_SHIFT +: 9];
        q_n400    = p_n16_reg[RECIP_SHIFT +: 7];
        q_t100    = p_t4_reg[RECIP_SHIFT +: 9];
        leaps     = n1_reg[15:2] - 14'(q_n100) + 14'(q_n400) + 14'd1;
        rem_t100  = t1_reg[15:2] - 14'(q_t100) * 14'd25;
        leap_next = (t1_reg[1:0] == 2'd0) && ((rem_t100 != '0) || (q_t100[1:0] == 2'd0));
        base_next = DAY_NUM_W'(t1_reg) * 24'd365 + DAY_NUM_W'(leaps);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base2_reg  <= base_next;
            leap2_reg  <= leap_next;
            pos2_reg   <= pos1_reg;
            yzero2_reg <= yzero1_reg;
            day2_reg   <= day1_reg;
            month2_reg <= month1_reg;
        end
    end

    // stage 3: day within year and date check
    logic [DAY_NUM_W-1:0] adj;
    logic                 bump;
    logic [5:0]           len;
    logic                 month_ok;
    date_res_t            res_next, res_reg;

    always_comb begin
        adj      = pos2_reg ? 24'd366 : 24'd0;
        bump     = (month2_reg > MONTH_FEB) && leap2_reg;
        month_ok = (month2_reg >= 4'd1) && (month2_reg <= 4'd12);
        len      = 6'(month_len(month2_reg))
                 + 6'((month2_reg == MONTH_FEB) && leap2_reg);
        res_next.day_num = base2_reg - adj + DAY_NUM_W'(cum_days(month2_reg))
                         + DAY_NUM_W'(day2_reg) - 24'd1 + DAY_NUM_W'(bump);
        res_next.ok      = !yzero2_reg && month_ok && (day2_reg != '0)
                         && (6'(day2_reg) <= len);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

@@ rtl/dbd_checker.sv @@
// ---------------------------------------------------------------------------
// dbd_checker
// port-level checks of days_between_dates, bound to the top level
// ---------------------------------------------------------------------------
`include "days_between_dates_assert.svh"

module dbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);
    logic       s_acc;
    logic       out_stall;
    logic [3:0] flow_reg;

    assign s_acc     = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;

    // accepted items that saw m_tready high in every cycle since, one bit per cycle of age
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_reg <= '0;
        end else begin
            flow_reg <= {flow_reg[2:0] & {3{m_tready}}, s_acc};
        end
    end

    // a stalled output item holds its payload
    `DBD_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // input side only backs off while the output item is stalled
    `DBD_ASSERT_NOW(a_ready_stall, !s_tready, out_stall)

    // an invalid pair reports no distance
    `DBD_ASSERT_NOW(a_invalid_zero, m_tvalid && m_tuser[0], m_tdata == 24'd0)

    // an accepted item reaches m_tvalid by the time it reaches flow_reg[3], when nothing stalls
    `DBD_ASSERT_NOW(a_latency, flow_reg[3], m_tvalid)

endmodule

bind days_between_dates dbd_checker u_dbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
